/* hdl/lcts_pkg.sv */
// ----------------------------------------------------------------------------
// lcts_pkg - shared definitions for the load cell tare stability check
// Field widths, status codes, register indexes, reset values and the
// record handed from the batch stage to the mean stage.
// ----------------------------------------------------------------------------
package lcts_pkg;

  localparam int SAMPLE_W = 24;
  localparam int NOW_W    = 32;
  localparam int LIMIT_W  = 24;
  localparam int DELAY_W  = 16;
  localparam int ATT_W    = 4;
  localparam int SUM_W    = 28;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam int BATCH_DEFAULT = 5;

  localparam logic [ATT_W-1:0] ATT_SAT = 4'd15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd2;

  // reset values
  localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RST = 24'd600;
  localparam logic [DELAY_W-1:0] RETRY_DELAY_RST  = 16'd2000;
  localparam logic [ATT_W-1:0]   MAX_ATTEMPTS_RST = 4'd3;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_RETRY   = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  // batch stage result, before the mean is formed
  typedef struct packed {
    status_t                   status;
    logic [ATT_W-1:0]          attempts;
    logic [SAMPLE_W-1:0]       spread;
    logic signed [SUM_W-1:0]   sum;
  } mid_t;

endpackage

/* hdl/lcts_mean_stage.sv */
// ----------------------------------------------------------------------------
// lcts_mean_stage - batch mean and result register
// Divides the batch sum by BATCH (truncating toward zero) with a reciprocal
// multiply and holds the finished result for the master side.
// ----------------------------------------------------------------------------
module lcts_mean_stage #(
  parameter int BATCH = lcts_pkg::BATCH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lcts_pkg::mid_t        in_rec,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,  // attempts[3:0], tare_value[27:4], spread[51:28], 0
  output logic [1:0]            m_tuser   // status[1:0]
);

  localparam int MAG_W   = lcts_pkg::SUM_W - 1;
  localparam int K       = MAG_W + $clog2(BATCH);
  localparam int RECIP_W = K + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + BATCH - 1) / BATCH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W  = MAG_W + RECIP_W;

  logic                          neg;
  logic [lcts_pkg::SUM_W-1:0]    sum_neg;
  logic [MAG_W-1:0]              mag;
  logic [PROD_W-1:0]             prod;
  logic [MAG_W-1:0]              quo;
  logic [MAG_W-1:0]              quo_signed;
  logic [lcts_pkg::SAMPLE_W-1:0] mean;

  lcts_pkg::status_t             out_status;
  logic [lcts_pkg::ATT_W-1:0]    out_attempts;
  logic [lcts_pkg::SAMPLE_W-1:0] out_tare;
  logic [lcts_pkg::SAMPLE_W-1:0] out_spread;

  // |sum| < 2^27, so the magnitude fits MAG_W bits
  assign neg        = in_rec.sum[lcts_pkg::SUM_W-1];
  assign sum_neg    = -in_rec.sum;
  assign mag        = neg ? sum_neg[MAG_W-1:0] : in_rec.sum[MAG_W-1:0];
  assign prod       = PROD_W'(mag) * PROD_W'(RECIP);
  assign quo        = prod[K +: MAG_W];
  assign quo_signed = neg ? (~quo + MAG_W'(1)) : quo;
  assign mean       = quo_signed[lcts_pkg::SAMPLE_W-1:0];

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_status   <= in_rec.status;
      out_attempts <= in_rec.attempts;
      out_spread   <= in_rec.spread;
      out_tare     <= (in_rec.status == lcts_pkg::ST_SUCCESS) ? mean : '0;
    end
  end

  assign m_tdata = {4'b0000, out_spread, out_tare, out_attempts};
  assign m_tuser = out_status;

endmodule

/* hdl/load_cell_tare_stability_check.sv */
// ----------------------------------------------------------------------------
// load_cell_tare_stability_check - tare stability check for a load cell
// Collects signed samples in batches, checks the spread of each batch and
// reports success with the batch mean, a retry with a wait deadline, or
// failure after too many unstable batches.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ---------------------------------------
//  s_*       in   s_tvalid / s_tready  tuser: mode; tdata: sample, now_ms
//  m_*       out  m_tvalid / m_tready  tuser: status; tdata: attempts,
//                                      tare_value, spread
//  cfg_*     in   cfg_we               cfg_index, cfg_data
//
//  One transaction in, one transaction out; a new one is taken every cycle unless m_tready stalls.
//  Data passes the input register, the batch stage and the mean stage in turn.
//  The batch next state is formed combinationally, so consecutive samples chain
//  without bubbles; the mean is a single reciprocal multiply in the last stage.
//  Sync active-high reset clears valids, batch state and loads register defaults.
//  A stall on m_tready backs up through the stages to s_tready; each stage
//  keeps taking data while the stage after it can move.
//
module load_cell_tare_stability_check #(
  parameter int BATCH = lcts_pkg::BATCH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,    // sample[23:0], now_ms[55:24]
  input  logic [0:0]  s_tuser,    // mode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // attempts[3:0], tare_value[27:4], spread[51:28], 0
  output logic [1:0]  m_tuser,    // status[1:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CNT_W = $clog2(BATCH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BATCH);

  // configuration registers
  logic [lcts_pkg::LIMIT_W-1:0]  spread_limit;
  logic [lcts_pkg::DELAY_W-1:0]  retry_delay_ms;
  logic [lcts_pkg::ATT_W-1:0]    max_attempts;

  // input register
  logic                                 in_valid;
  logic                                 in_mode;
  logic signed [lcts_pkg::SAMPLE_W-1:0] in_sample;
  logic [lcts_pkg::NOW_W-1:0]           in_now;

  // batch state
  logic signed [lcts_pkg::SAMPLE_W-1:0] batch_min, batch_min_next;
  logic signed [lcts_pkg::SAMPLE_W-1:0] batch_max, batch_max_next;
  logic signed [lcts_pkg::SUM_W-1:0]    batch_sum, batch_sum_next;
  logic [CNT_W-1:0]                     sample_count, sample_count_next;
  logic [lcts_pkg::ATT_W-1:0]           attempt_count, attempt_count_next;
  logic [lcts_pkg::NOW_W-1:0]           retry_deadline, retry_deadline_next;
  logic                                 retry_pending, retry_pending_next;

  // stage between batch logic and mean
  logic            mid_valid;
  lcts_pkg::mid_t  mid_rec, mid_rec_next;
  logic            mid_ready;
  logic            div_ready;
  logic            in_adv;

  // batch stage temporaries
  logic [CNT_W-1:0]                cnt_inc;
  logic signed [lcts_pkg::SAMPLE_W:0] diff;
  logic [lcts_pkg::SAMPLE_W-1:0]   spread_cur;
  logic [lcts_pkg::ATT_W-1:0]      att_inc;

  // ---- handshake chain ----
  assign mid_ready = !mid_valid || div_ready;
  assign in_adv    = in_valid && mid_ready;
  assign s_tready  = !in_valid || in_adv;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_limit   <= lcts_pkg::SPREAD_LIMIT_RST;
      retry_delay_ms <= lcts_pkg::RETRY_DELAY_RST;
      max_attempts   <= lcts_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcts_pkg::REG_SPREAD_LIMIT: spread_limit   <= cfg_data[lcts_pkg::LIMIT_W-1:0];
        lcts_pkg::REG_RETRY_DELAY:  retry_delay_ms <= cfg_data[lcts_pkg::DELAY_W-1:0];
        lcts_pkg::REG_MAX_ATTEMPTS: max_attempts   <= cfg_data[lcts_pkg::ATT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser[0];
      in_sample <= s_tdata[23:0];
      in_now    <= s_tdata[55:24];
    end
  end

  // ---- batch stage ----
  always_comb begin
    batch_min_next      = batch_min;
    batch_max_next      = batch_max;
    batch_sum_next      = batch_sum;
    sample_count_next   = sample_count;
    attempt_count_next  = attempt_count;
    retry_deadline_next = retry_deadline;
    retry_pending_next  = retry_pending;
    cnt_inc             = sample_count + CNT_W'(1);
    att_inc             = (attempt_count < lcts_pkg::ATT_SAT) ?
                          attempt_count + lcts_pkg::ATT_W'(1) : attempt_count;
    diff                = '0;
    spread_cur          = '0;

    mid_rec_next.status   = lcts_pkg::ST_BUSY;
    mid_rec_next.attempts = attempt_count;
    mid_rec_next.spread   = '0;
    mid_rec_next.sum      = '0;

    if (in_mode) begin
      // restart: drop the running batch, attempts and any deadline
      batch_min_next        = '0;
      batch_max_next        = '0;
      batch_sum_next        = '0;
      sample_count_next     = '0;
      attempt_count_next    = '0;
      retry_deadline_next   = '0;
      retry_pending_next    = 1'b0;
      mid_rec_next.attempts = '0;
    end else if (retry_pending && (in_now < retry_deadline)) begin
      // still waiting out the retry delay: sample dropped
    end else begin
      retry_pending_next = 1'b0;
      if (sample_count == '0) begin
        batch_min_next = in_sample;
        batch_max_next = in_sample;
        batch_sum_next = lcts_pkg::SUM_W'(in_sample);
      end else begin
        if (in_sample < batch_min) batch_min_next = in_sample;
        if (in_sample > batch_max) batch_max_next = in_sample;
        batch_sum_next = batch_sum + lcts_pkg::SUM_W'(in_sample);
      end

      diff       = (lcts_pkg::SAMPLE_W+1)'(batch_max_next) -
                   (lcts_pkg::SAMPLE_W+1)'(batch_min_next);
      spread_cur = diff[lcts_pkg::SAMPLE_W-1:0];

      if (cnt_inc == CNT_LAST) begin
        sample_count_next   = '0;
        mid_rec_next.spread = spread_cur;
        if (spread_cur < spread_limit) begin
          mid_rec_next.status = lcts_pkg::ST_SUCCESS;
          mid_rec_next.sum    = batch_sum_next;
        end else begin
          attempt_count_next    = att_inc;
          mid_rec_next.attempts = att_inc;
          if (att_inc >= max_attempts) begin
            mid_rec_next.status = lcts_pkg::ST_FAILED;
          end else begin
            mid_rec_next.status = lcts_pkg::ST_RETRY;
            retry_deadline_next = in_now + lcts_pkg::NOW_W'(retry_delay_ms);
            retry_pending_next  = 1'b1;
          end
        end
      end else begin
        sample_count_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_min      <= '0;
      batch_max      <= '0;
      batch_sum      <= '0;
      sample_count   <= '0;
      attempt_count  <= '0;
      retry_deadline <= '0;
      retry_pending  <= 1'b0;
    end else if (in_adv) begin
      batch_min      <= batch_min_next;
      batch_max      <= batch_max_next;
      batch_sum      <= batch_sum_next;
      sample_count   <= sample_count_next;
      attempt_count  <= attempt_count_next;
      retry_deadline <= retry_deadline_next;
      retry_pending  <= retry_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      mid_rec <= mid_rec_next;
    end
  end

  // ---- mean and output register ----
  lcts_mean_stage #(
    .BATCH (BATCH)
  ) u_mean (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .in_ready (div_ready),
    .in_rec   (mid_rec),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // partial batch count never reaches the batch size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (sample_count < CNT_LAST))
    else $error("sample_count reached batch size");

  // a pending retry only follows an unstable batch
  a_pending_attempts: assert property (@(posedge clk) disable iff (rst)
    retry_pending |-> (attempt_count != '0))
    else $error("retry pending with zero attempts");

  // a completed batch restarts the count
  a_batch_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_adv && (mid_rec_next.status != lcts_pkg::ST_BUSY)) |=> (sample_count == '0))
    else $error("sample count not cleared after batch");

  // busy results carry no spread or tare
  a_busy_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == lcts_pkg::ST_BUSY)) |-> (m_tdata[51:4] == '0))
    else $error("busy result with nonzero payload");

  // retry and failure always count an attempt
  a_fail_attempts: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == lcts_pkg::ST_RETRY) || (m_tuser == lcts_pkg::ST_FAILED)))
      |-> (m_tdata[3:0] != 4'd0))
    else $error("retry or failure with zero attempts");
`endif

endmodule
